// ===== sv/kmc_pkg.sv =====
// ----------------------------------------------------------------------------
// kmc_pkg
// Codes shared by the k-means block: item kinds, result kinds, register index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kmc_pkg;

    // input item kinds
    localparam logic [1:0] KIND_LOAD_POINT    = 2'd0;
    localparam logic [1:0] KIND_LOAD_CENTROID = 2'd1;
    localparam logic [1:0] KIND_RUN           = 2'd2;
    localparam logic [1:0] KIND_QUERY         = 2'd3;

    // result kinds
    localparam logic [1:0] RES_CENTROID = 2'd0;
    localparam logic [1:0] RES_ITERS    = 2'd1;
    localparam logic [1:0] RES_ASSIGN   = 2'd2;

    // configuration register index
    localparam logic [1:0] CFG_NUM_POINTS   = 2'd0;
    localparam logic [1:0] CFG_NUM_CLUSTERS = 2'd1;
    localparam logic [1:0] CFG_MAX_ITERS    = 2'd2;
    localparam logic [1:0] CFG_TOLERANCE_SQ = 2'd3;

    localparam int CFG_DATA_BITS = 35;
    localparam int INDEX_BITS    = 10;
    localparam int VALUE_BITS    = 8;

endpackage

`default_nettype wire

// ===== sv/kmc_if.sv =====
// ----------------------------------------------------------------------------
// kmc_if
// Valid/ready channels of the k-means block: input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kmc_in_if #(
    parameter int COORD_BITS = 16
);
    logic                              valid;
    logic                              ready;
    logic [1:0]                        kind;
    logic [kmc_pkg::INDEX_BITS-1:0]    item_index;
    logic signed [COORD_BITS-1:0]      coord_x;
    logic signed [COORD_BITS-1:0]      coord_y;

    modport source (output valid, kind, item_index, coord_x, coord_y, input ready);
    modport sink   (input valid, kind, item_index, coord_x, coord_y, output ready);
endinterface

interface kmc_out_if #(
    parameter int COORD_BITS = 16
);
    logic                              valid;
    logic                              ready;
    logic [1:0]                        result_kind;
    logic [kmc_pkg::INDEX_BITS-1:0]    result_index;
    logic signed [COORD_BITS-1:0]      result_x;
    logic signed [COORD_BITS-1:0]      result_y;
    logic [kmc_pkg::VALUE_BITS-1:0]    result_value;
    logic                              last_result;

    modport source (output valid, result_kind, result_index, result_x, result_y,
                    result_value, last_result, input ready);
    modport sink   (input valid, result_kind, result_index, result_x, result_y,
                    result_value, last_result, output ready);
endinterface

`default_nettype wire

// ===== sv/kmc_div.sv =====
// ----------------------------------------------------------------------------
// kmc_div
// Iterative signed by unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmc_div #(
    parameter int SW = 27,
    parameter int NW = 11
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire signed [SW-1:0]  i_num,
    input  wire        [NW-1:0]  i_den,
    output logic                 o_done,
    output logic signed [SW-1:0] o_quo
);

    localparam int CNTW = $clog2(SW + 1);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [SW-1:0]   r_mag;
    logic [NW-1:0]   r_rem;
    logic [NW-1:0]   r_den;
    logic            r_neg;
    logic            r_done;

    logic [NW:0]     w_rem_sh;
    logic            w_ge;
    logic [NW:0]     w_rem_sub;

    assign w_rem_sh  = {r_rem, r_mag[SW-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_den};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(SW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[SW-1];
            r_mag <= i_num[SW-1] ? (SW'(0) - i_num) : i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_rem_sub[NW-1:0] : w_rem_sh[NW-1:0];
            r_mag <= {r_mag[SW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? signed'(SW'(0) - r_mag) : signed'(r_mag);

endmodule

`default_nettype wire

// ===== sv/kmeans_2d_clustering.sv =====
// ----------------------------------------------------------------------------
// kmeans_2d_clustering
// Lloyd k-means on 2D integer points held in on-chip memories.
// ----------------------------------------------------------------------------
//  channel    dir  beat
//  i_item     in   kind, item_index, coord_x, coord_y
//  o_result   out  result_kind, result_index, result_x, result_y, value, last
//  i_cfg_*    in   write enable, register index, data
//
//  load and query items are taken one per cycle while idle; a query result is
//  read from memory and set into the output register once that register is free.
//  each round of a run uses the shared distance datapath and the serial mean
//  dividers (SW = sum width); the run then emits k+1 beats.
//  after reset a clearing pass zeroes all MAX_POINTS assignments;
//  no item is taken during it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmeans_2d_clustering #(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_CLUSTERS = 16,
    parameter int COORD_BITS   = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    kmc_in_if.sink                               i_item,
    kmc_out_if.source                            o_result,
    input  wire                                  i_cfg_we,
    input  wire [1:0]                            i_cfg_idx,
    input  wire [kmc_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int CB  = COORD_BITS;
    localparam int PW  = $clog2(MAX_POINTS);
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int CW  = $clog2(MAX_CLUSTERS);
    localparam int KW  = $clog2(MAX_CLUSTERS + 1);
    localparam int SW  = CB + PW + 1;
    localparam int DW  = 2 * CB + 3;
    localparam int TW  = (DW > kmc_pkg::CFG_DATA_BITS) ? DW : kmc_pkg::CFG_DATA_BITS;
    localparam int IW  = kmc_pkg::INDEX_BITS;
    localparam int VW  = kmc_pkg::VALUE_BITS;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_QOUT  = 5'd2;
    localparam logic [4:0] S_RST   = 5'd3;
    localparam logic [4:0] S_APRD  = 5'd4;
    localparam logic [4:0] S_AWT   = 5'd5;
    localparam logic [4:0] S_ADX   = 5'd6;
    localparam logic [4:0] S_ASQ   = 5'd7;
    localparam logic [4:0] S_ACMP  = 5'd8;
    localparam logic [4:0] S_AWR   = 5'd9;
    localparam logic [4:0] S_UCHK  = 5'd10;
    localparam logic [4:0] S_UDIV  = 5'd11;
    localparam logic [4:0] S_UDX   = 5'd12;
    localparam logic [4:0] S_USQ   = 5'd13;
    localparam logic [4:0] S_UCMP  = 5'd14;
    localparam logic [4:0] S_UNXT  = 5'd15;
    localparam logic [4:0] S_RDONE = 5'd16;
    localparam logic [4:0] S_EMIT  = 5'd17;
    localparam logic [4:0] S_ECNT  = 5'd18;

    // configuration
    logic [10:0]                        r_num_points;
    logic [4:0]                         r_num_clusters;
    logic [7:0]                         r_max_iters;
    logic [kmc_pkg::CFG_DATA_BITS-1:0]  r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points   <= 11'd1;
            r_num_clusters <= 5'd1;
            r_max_iters    <= 8'd16;
            r_tol          <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kmc_pkg::CFG_NUM_POINTS:   r_num_points   <= i_cfg_data[10:0];
                kmc_pkg::CFG_NUM_CLUSTERS: r_num_clusters <= i_cfg_data[4:0];
                kmc_pkg::CFG_MAX_ITERS:    r_max_iters    <= i_cfg_data[7:0];
                kmc_pkg::CFG_TOLERANCE_SQ: r_tol          <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [NW-1:0] w_n;
    logic [KW-1:0] w_k;
    logic [CW-1:0] w_klast;

    assign w_n = (int'(r_num_points) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(r_num_points);
    assign w_k = (r_num_clusters == 5'd0) ? KW'(1) :
                 (int'(r_num_clusters) > MAX_CLUSTERS) ? KW'(MAX_CLUSTERS) :
                 KW'(r_num_clusters);
    assign w_klast = CW'(w_k - 1'b1);

    // control and datapath registers
    logic [4:0]            r_state;
    logic [PW-1:0]         r_clr;
    logic [NW-1:0]         r_i;
    logic [CW-1:0]         r_c;
    logic [CW-1:0]         r_best;
    logic [DW-1:0]         r_best_d;
    logic [DW-1:0]         r_max;
    logic [7:0]            r_it;
    logic [IW-1:0]         r_qidx;
    logic                  r_qok;
    logic signed [CB:0]    r_dx;
    logic signed [CB:0]    r_dy;
    logic [2*CB+1:0]       r_sqx;
    logic [2*CB+1:0]       r_sqy;
    logic signed [CB-1:0]  r_nx;
    logic signed [CB-1:0]  r_ny;

    logic signed [CB-1:0]  r_cx [MAX_CLUSTERS];
    logic signed [CB-1:0]  r_cy [MAX_CLUSTERS];
    logic signed [SW-1:0]  r_sx [MAX_CLUSTERS];
    logic signed [SW-1:0]  r_sy [MAX_CLUSTERS];
    logic [NW-1:0]         r_cnt [MAX_CLUSTERS];

    // output register
    logic                  r_ov;
    logic [1:0]            r_okind;
    logic [IW-1:0]         r_oidx;
    logic signed [CB-1:0]  r_ox;
    logic signed [CB-1:0]  r_oy;
    logic [VW-1:0]         r_oval;
    logic                  r_olast;

    // memories
    logic [2*CB-1:0]       m_pt [MAX_POINTS];
    logic [CW-1:0]         m_cl [MAX_POINTS];
    logic [2*CB-1:0]       r_prd;
    logic [CW-1:0]         r_crd;

    logic w_in_acc;
    logic w_slot;
    logic w_oset;
    assign w_in_acc = i_item.valid && i_item.ready;
    assign w_slot   = !r_ov || o_result.ready;
    assign w_oset   = w_slot && (r_state == S_QOUT || r_state == S_EMIT ||
                                 r_state == S_ECNT);
    assign i_item.ready = (r_state == S_IDLE);

    logic [PW-1:0] w_iaddr;
    assign w_iaddr = PW'(i_item.item_index);
    logic w_pt_ok;
    logic w_ct_ok;
    assign w_pt_ok = int'(i_item.item_index) < MAX_POINTS;
    assign w_ct_ok = int'(i_item.item_index) < MAX_CLUSTERS;

    logic signed [CB-1:0] w_px;
    logic signed [CB-1:0] w_py;
    assign w_px = signed'(r_prd[CB-1:0]);
    assign w_py = signed'(r_prd[2*CB-1:CB]);

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_item.kind == kmc_pkg::KIND_LOAD_POINT && w_pt_ok) begin
            m_pt[w_iaddr] <= {i_item.coord_y, i_item.coord_x};
        end
        if (r_state == S_APRD) begin
            r_prd <= m_pt[PW'(r_i)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            m_cl[r_clr] <= '0;
        end else if (r_state == S_AWR) begin
            m_cl[PW'(r_i)] <= r_best;
        end
        if (w_in_acc && i_item.kind == kmc_pkg::KIND_QUERY) begin
            r_crd <= m_cl[w_iaddr];
        end
    end

    // shared distance datapath
    logic signed [CB-1:0] w_ax, w_ay, w_bx, w_by;
    logic [DW-1:0]        w_dist;

    always_comb begin
        if (r_state == S_UDX) begin
            w_ax = r_cx[r_c];
            w_ay = r_cy[r_c];
            w_bx = r_nx;
            w_by = r_ny;
        end else begin
            w_ax = w_px;
            w_ay = w_py;
            w_bx = r_cx[r_c];
            w_by = r_cy[r_c];
        end
    end

    assign w_dist = DW'(r_sqx) + DW'(r_sqy);

    always_ff @(posedge i_clk) begin
        r_dx  <= (CB+1)'(w_ax) - (CB+1)'(w_bx);
        r_dy  <= (CB+1)'(w_ay) - (CB+1)'(w_by);
        r_sqx <= (2*CB+2)'(r_dx * r_dx);
        r_sqy <= (2*CB+2)'(r_dy * r_dy);
    end

    // cluster accumulator read port
    logic [CW-1:0]        w_sidx;
    logic signed [SW-1:0] w_sx, w_sy;
    logic [NW-1:0]        w_cnt;
    assign w_sidx = (r_state == S_AWR) ? r_best : r_c;
    assign w_sx   = r_sx[w_sidx];
    assign w_sy   = r_sy[w_sidx];
    assign w_cnt  = r_cnt[w_sidx];

    // mean dividers
    logic                 w_div_go;
    logic                 w_dx_done, w_dy_done;
    logic signed [SW-1:0] w_qx, w_qy;
    assign w_div_go = (r_state == S_UCHK) && (w_cnt != '0);

    kmc_div #(.SW(SW), .NW(NW)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_go),
        .i_num(w_sx), .i_den(w_cnt), .o_done(w_dx_done), .o_quo(w_qx)
    );

    kmc_div #(.SW(SW), .NW(NW)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_go),
        .i_num(w_sy), .i_den(w_cnt), .o_done(w_dy_done), .o_quo(w_qy)
    );

    logic w_conv;
    assign w_conv = TW'(r_max) < TW'(r_tol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && o_result.ready && !w_oset) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == PW'(MAX_POINTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_item.kind)
                            kmc_pkg::KIND_LOAD_CENTROID: begin
                                if (w_ct_ok) begin
                                    r_cx[CW'(i_item.item_index)] <= i_item.coord_x;
                                    r_cy[CW'(i_item.item_index)] <= i_item.coord_y;
                                end
                            end
                            kmc_pkg::KIND_RUN: begin
                                r_it    <= '0;
                                r_state <= S_RST;
                            end
                            kmc_pkg::KIND_QUERY: begin
                                r_qidx  <= i_item.item_index;
                                r_qok   <= w_pt_ok;
                                r_state <= S_QOUT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_QOUT: begin
                    if (w_slot) begin
                        r_ov    <= 1'b1;
                        r_okind <= kmc_pkg::RES_ASSIGN;
                        r_oidx  <= r_qidx;
                        r_ox    <= '0;
                        r_oy    <= '0;
                        r_oval  <= r_qok ? VW'(r_crd) : '0;
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_RST: begin
                    for (int c = 0; c < MAX_CLUSTERS; c++) begin
                        r_sx[c]  <= '0;
                        r_sy[c]  <= '0;
                        r_cnt[c] <= '0;
                    end
                    r_i   <= '0;
                    r_max <= '0;
                    r_c   <= '0;
                    r_state <= (r_it == r_max_iters) ? S_EMIT : S_APRD;
                end
                S_APRD: begin
                    r_c <= '0;
                    r_state <= (r_i == w_n) ? S_UCHK : S_AWT;
                end
                S_AWT: r_state <= S_ADX;
                S_ADX: r_state <= S_ASQ;
                S_ASQ: r_state <= S_ACMP;
                S_ACMP: begin
                    if (r_c == '0 || w_dist < r_best_d) begin
                        r_best   <= r_c;
                        r_best_d <= w_dist;
                    end
                    if (r_c == w_klast) begin
                        r_state <= S_AWR;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_ADX;
                    end
                end
                S_AWR: begin
                    r_sx[r_best]  <= w_sx + SW'(w_px);
                    r_sy[r_best]  <= w_sy + SW'(w_py);
                    r_cnt[r_best] <= w_cnt + 1'b1;
                    r_i     <= r_i + 1'b1;
                    r_state <= S_APRD;
                end
                S_UCHK: begin
                    r_state <= (w_cnt == '0) ? S_UNXT : S_UDIV;
                end
                S_UDIV: begin
                    if (w_dx_done && w_dy_done) begin
                        r_nx    <= CB'(w_qx);
                        r_ny    <= CB'(w_qy);
                        r_state <= S_UDX;
                    end
                end
                S_UDX: r_state <= S_USQ;
                S_USQ: r_state <= S_UCMP;
                S_UCMP: begin
                    if (w_dist > r_max) begin
                        r_max <= w_dist;
                    end
                    r_cx[r_c] <= r_nx;
                    r_cy[r_c] <= r_ny;
                    r_state   <= S_UNXT;
                end
                S_UNXT: begin
                    if (r_c == w_klast) begin
                        r_state <= S_RDONE;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_UCHK;
                    end
                end
                S_RDONE: begin
                    r_it <= r_it + 1'b1;
                    r_c  <= '0;
                    r_state <= w_conv ? S_EMIT : S_RST;
                end
                S_EMIT: begin
                    if (w_slot) begin
                        r_ov    <= 1'b1;
                        r_okind <= kmc_pkg::RES_CENTROID;
                        r_oidx  <= IW'(r_c);
                        r_ox    <= r_cx[r_c];
                        r_oy    <= r_cy[r_c];
                        r_oval  <= '0;
                        r_olast <= 1'b0;
                        if (r_c == w_klast) begin
                            r_state <= S_ECNT;
                        end else begin
                            r_c <= r_c + 1'b1;
                        end
                    end
                end
                S_ECNT: begin
                    if (w_slot) begin
                        r_ov    <= 1'b1;
                        r_okind <= kmc_pkg::RES_ITERS;
                        r_oidx  <= '0;
                        r_ox    <= '0;
                        r_oy    <= '0;
                        r_oval  <= r_it;
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid        = r_ov;
    assign o_result.result_kind  = r_okind;
    assign o_result.result_index = r_oidx;
    assign o_result.result_x     = r_ox;
    assign o_result.result_y     = r_oy;
    assign o_result.result_value = r_oval;
    assign o_result.last_result  = r_olast;

endmodule

`default_nettype wire
